// ===== design/clfsr_pkg.sv =====
// ----------------------------------------------------------------------------
// clfsr_pkg
// Types and constants shared by the combined LFSR generator and its channels.
// ----------------------------------------------------------------------------
package clfsr_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned CntW     = 6;    // holds 0..32
  localparam int unsigned MaxBits  = 32;
  localparam int unsigned MaxDraws = 256;
  localparam int unsigned RejW     = 8;

  localparam logic [WordW-1:0] DefaultSeed = 32'h000A_CE01;
  localparam logic [WordW-1:0] TapsAReset  = 32'h8020_0003;
  localparam logic [WordW-1:0] TapsBReset  = 32'h4800_0000;
  localparam logic [WordW-1:0] TapsCReset  = 32'h1400_0000;

  typedef enum logic [1:0] {
    KIND_SEED = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_BITS = 2'd2,
    KIND_INT  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_TAPS_A = 2'd0,
    CFG_TAPS_B = 2'd1,
    CFG_TAPS_C = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    kind_e             kind;
    logic [WordW-1:0]  seed_value;
    logic [WordW-1:0]  load_a;
    logic [WordW-1:0]  load_b;
    logic [WordW-1:0]  load_c;
    logic [CntW-1:0]   bit_count;
    logic [WordW-1:0]  range_low;
    logic [WordW-1:0]  range_high;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0]  value;
    logic              refused;
    logic [WordW-1:0]  state_a;
    logic [WordW-1:0]  state_b;
    logic [WordW-1:0]  state_c;
  } rsp_t;

endpackage

// ===== design/clfsr_req_if.sv =====
// ----------------------------------------------------------------------------
// clfsr_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface clfsr_req_if;
  logic               valid;
  logic               ready;
  clfsr_pkg::req_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/clfsr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// clfsr_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface clfsr_rsp_if;
  logic               valid;
  logic               ready;
  clfsr_pkg::rsp_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/combined_lfsr_random_generator_core.sv =====
// ----------------------------------------------------------------------------
// combined_lfsr_random_generator_core
// Three Galois LFSRs stepped one bit per cycle in warm-up and draws; seed, load, bit and range draws.
// ----------------------------------------------------------------------------
// A bit request draws its bits (none for zero bits); a range request sizes the
// bit length L of the span, then draws words of width w and checks each, with
// D the number of draws (at most 256).
// One generator bit per cycle while drawing, through the shared LFSR step; one word at a time.
// Reset loads all LFSRs with 0xACE01 and runs the warm-up steps before the
// request side goes ready; a pending result does not block accept.
module combined_lfsr_random_generator_core #(
  parameter int unsigned WARMUP_STEPS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  clfsr_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [clfsr_pkg::WordW-1:0]     cfg_data_i,
  clfsr_req_if.sink                       req_i,
  clfsr_rsp_if.source                     rsp_o
);
  import clfsr_pkg::*;

  localparam int unsigned WarmW = $clog2(WARMUP_STEPS + 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM,
    ST_SIZE,
    ST_DRAW,
    ST_CHECK,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [WordW-1:0]  taps_a_q, taps_b_q, taps_c_q;
  logic [WordW-1:0]  lfsr_a_q, lfsr_b_q, lfsr_c_q;
  logic [WordW-1:0]  lfsr_a_d, lfsr_b_d, lfsr_c_d;
  logic [WarmW-1:0]  warm_q, warm_d;
  logic              emit_q, emit_d;
  logic              range_q, range_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   width_q, width_d;
  logic [RejW-1:0]   rej_q, rej_d;
  logic [WordW-1:0]  acc_q, acc_d;
  logic [WordW-1:0]  diff_q, diff_d;
  logic [WordW-1:0]  dsh_q, dsh_d;
  logic [WordW-1:0]  lo_q, lo_d;
  logic              refused_q, refused_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic              step_en;
  logic              gen_bit;
  logic [WordW-1:0]  step_a, step_b, step_c;
  logic [WordW-1:0]  seed;
  logic [CntW-1:0]   n_bits;
  logic              slot_free;

  // One Galois step of each LFSR: shift right, fold in the taps on a one.
  always_comb begin
    step_a  = (lfsr_a_q >> 1) ^ (lfsr_a_q[0] ? taps_a_q : '0);
    step_b  = (lfsr_b_q >> 1) ^ (lfsr_b_q[0] ? taps_b_q : '0);
    step_c  = (lfsr_c_q >> 1) ^ (lfsr_c_q[0] ? taps_c_q : '0);
    gen_bit = lfsr_a_q[0] ^ lfsr_b_q[0] ^ lfsr_c_q[0];
  end

  assign step_en   = (state_q == ST_DRAW) || ((state_q == ST_WARM) && (warm_q != '0));
  assign seed      = (req_i.payload.seed_value == '0) ? DefaultSeed : req_i.payload.seed_value;
  assign n_bits    = (req_i.payload.bit_count > CntW'(MaxBits)) ? CntW'(MaxBits)
                                                                : req_i.payload.bit_count;
  assign slot_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  always_comb begin
    state_d     = state_q;
    lfsr_a_d    = step_en ? step_a : lfsr_a_q;
    lfsr_b_d    = step_en ? step_b : lfsr_b_q;
    lfsr_c_d    = step_en ? step_c : lfsr_c_q;
    warm_d      = warm_q;
    emit_d      = emit_q;
    range_d     = range_q;
    cnt_d       = cnt_q;
    width_d     = width_q;
    rej_d       = rej_q;
    acc_d       = acc_q;
    diff_d      = diff_q;
    dsh_d       = dsh_q;
    lo_d        = lo_q;
    refused_d   = refused_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          acc_d     = '0;
          refused_d = 1'b0;
          case (req_i.payload.kind)
            KIND_SEED: begin
              lfsr_a_d = seed;
              lfsr_b_d = seed;
              lfsr_c_d = seed;
              warm_d   = WarmW'(WARMUP_STEPS);
              emit_d   = 1'b1;
              state_d  = ST_WARM;
            end
            KIND_LOAD: begin
              if ((req_i.payload.load_a == '0) || (req_i.payload.load_b == '0) ||
                  (req_i.payload.load_c == '0)) begin
                refused_d = 1'b1;
              end else begin
                lfsr_a_d = req_i.payload.load_a;
                lfsr_b_d = req_i.payload.load_b;
                lfsr_c_d = req_i.payload.load_c;
              end
              state_d = ST_FINISH;
            end
            KIND_BITS: begin
              range_d = 1'b0;
              cnt_d   = n_bits;
              state_d = (n_bits == '0) ? ST_FINISH : ST_DRAW;
            end
            default: begin
              range_d = 1'b1;
              lo_d    = req_i.payload.range_low;
              diff_d  = req_i.payload.range_high - req_i.payload.range_low;
              dsh_d   = req_i.payload.range_high - req_i.payload.range_low;
              cnt_d   = '0;
              state_d = ST_SIZE;
            end
          endcase
        end
      end
      ST_WARM: begin
        if (warm_q == '0) begin
          state_d = emit_q ? ST_FINISH : ST_IDLE;
        end else begin
          warm_d = warm_q - WarmW'(1);
        end
      end
      ST_SIZE: begin
        // bit length of the span, one bit a cycle; never narrower than one
        if (dsh_q == '0) begin
          width_d = (cnt_q == '0) ? CntW'(1) : cnt_q;
          cnt_d   = (cnt_q == '0) ? CntW'(1) : cnt_q;
          rej_d   = '0;
          acc_d   = '0;
          state_d = ST_DRAW;
        end else begin
          dsh_d = dsh_q >> 1;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_DRAW: begin
        acc_d = {acc_q[WordW-2:0], gen_bit};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = range_q ? ST_CHECK : ST_FINISH;
        end
      end
      ST_CHECK: begin
        if (acc_q <= diff_q) begin
          acc_d   = lo_q + acc_q;
          state_d = ST_FINISH;
        end else if (rej_q == RejW'(MaxDraws - 1)) begin
          // give up on a stuck stream: saturate to the top of the range
          acc_d   = lo_q + diff_q;
          state_d = ST_FINISH;
        end else begin
          rej_d   = rej_q + RejW'(1);
          cnt_d   = width_q;
          acc_d   = '0;
          state_d = ST_DRAW;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_d   = 1'b1;
          out_d.value   = acc_q;
          out_d.refused = refused_q;
          out_d.state_a = lfsr_a_q;
          out_d.state_b = lfsr_b_q;
          out_d.state_c = lfsr_c_q;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WARM;
      taps_a_q    <= TapsAReset;
      taps_b_q    <= TapsBReset;
      taps_c_q    <= TapsCReset;
      lfsr_a_q    <= DefaultSeed;
      lfsr_b_q    <= DefaultSeed;
      lfsr_c_q    <= DefaultSeed;
      warm_q      <= WarmW'(WARMUP_STEPS);
      emit_q      <= 1'b0;
      range_q     <= 1'b0;
      cnt_q       <= '0;
      width_q     <= '0;
      rej_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lfsr_a_q    <= lfsr_a_d;
      lfsr_b_q    <= lfsr_b_d;
      lfsr_c_q    <= lfsr_c_d;
      warm_q      <= warm_d;
      emit_q      <= emit_d;
      range_q     <= range_d;
      cnt_q       <= cnt_d;
      width_q     <= width_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TAPS_A: taps_a_q <= cfg_data_i;
          CFG_TAPS_B: taps_b_q <= cfg_data_i;
          CFG_TAPS_C: taps_c_q <= cfg_data_i;
          default: ;  // drop writes beyond the register list
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    diff_q    <= diff_d;
    dsh_q     <= dsh_d;
    lo_q      <= lo_d;
    refused_q <= refused_d;
    out_q     <= out_d;
  end

  // one word in flight: no second accept right after the first
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while a word is in progress");

  a_draw_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> (cnt_q != '0))
    else $error("draw state entered with no bits left");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.payload.refused) |-> (rsp_o.payload.value == '0))
    else $error("refused load carries a nonzero value");

  a_check_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> range_q)
    else $error("range check reached on a bit draw");

endmodule
